FILE: rtl/core/cppe_pkg.sv
// Shared types and constants of the clipped page pixel engine.
`default_nettype none

package cppe_pkg;

  localparam int unsigned MODE_W  = 3;
  localparam int unsigned COORD_W = 11;
  localparam int unsigned PIX_W   = 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_KEYED  = 3'd0,
    MODE_OPAQUE = 3'd1,
    MODE_READ   = 3'd2,
    MODE_SPAN   = 3'd3,
    MODE_CLEAR  = 3'd4
  } mode_t;

  typedef struct packed {
    logic load;
    logic setup;
    logic wr;
    logic step;
    logic rd;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic do_write;
    logic do_read;
    logic last;
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/cppe_datapath.sv
// Datapath: command registers, clipping, address generation, page store and result register.
`default_nettype none

module cppe_datapath #(
  parameter int unsigned PAGE_WIDTH  = 512,
  parameter int unsigned PAGE_HEIGHT = 256
) (
  input  logic                                  clk,
  input  cppe_pkg::cmd_t                        cmd,
  output cppe_pkg::sts_t                        sts,
  input  logic [cppe_pkg::MODE_W-1:0]           in_mode,
  input  logic signed [cppe_pkg::COORD_W-1:0]   in_x,
  input  logic signed [cppe_pkg::COORD_W-1:0]   in_y,
  input  logic signed [cppe_pkg::COORD_W-1:0]   in_xe,
  input  logic [cppe_pkg::PIX_W-1:0]            in_val,
  output logic [cppe_pkg::PIX_W-1:0]            out_read_value,
  output logic                                  out_inside
);
  import cppe_pkg::*;

  localparam int unsigned DEPTH = PAGE_WIDTH * PAGE_HEIGHT;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned XW    = $clog2(PAGE_WIDTH);
  localparam int unsigned YW    = $clog2(PAGE_HEIGHT);
  localparam int unsigned CW    = COORD_W + 1;
  localparam logic signed [CW-1:0] W_S = CW'(PAGE_WIDTH);
  localparam logic signed [CW-1:0] H_S = CW'(PAGE_HEIGHT);

  logic [PIX_W-1:0] mem [DEPTH];

  mode_t                     mode_r;
  logic signed [COORD_W-1:0] x_r;
  logic signed [COORD_W-1:0] y_r;
  logic signed [COORD_W-1:0] xe_r;
  logic [PIX_W-1:0]          val_r;
  logic                      inside_r;
  logic                      rsel_r;
  logic [AW-1:0]             addr;
  logic [AW-1:0]             cnt;
  logic [PIX_W-1:0]          rdata;

  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic signed [CW-1:0] xes;
  logic signed [CW-1:0] span_a;
  logic signed [CW-1:0] span_b;
  logic signed [CW-1:0] span_len;
  logic signed [CW-1:0] col;
  logic                 x_ok;
  logic                 y_ok;
  logic                 pix_ok;
  logic                 span_ok;
  logic                 inside_next;
  logic [AW-1:0]        addr_next;
  logic [AW-1:0]        cnt_next;

  always_comb begin
    xs       = CW'(x_r);
    ys       = CW'(y_r);
    xes      = CW'(xe_r);
    x_ok     = (xs >= 0) && (xs < W_S);
    y_ok     = (ys >= 0) && (ys < H_S);
    pix_ok   = x_ok && y_ok;
    span_a   = (xs < 0) ? CW'(0) : xs;
    span_b   = (xes >= W_S) ? (W_S - CW'(1)) : xes;
    span_ok  = y_ok && (span_a <= span_b);
    span_len = span_b - span_a;
    col      = (mode_r == MODE_SPAN) ? span_a : xs;
    sts.do_write = 1'b0;
    sts.do_read  = 1'b0;
    inside_next  = 1'b0;
    addr_next    = AW'(ys[YW-1:0]) * AW'(PAGE_WIDTH) + AW'(col[XW-1:0]);
    cnt_next     = '0;
    case (mode_r)
      MODE_KEYED: begin
        inside_next  = pix_ok;
        sts.do_write = pix_ok && (val_r != '0);
      end
      MODE_OPAQUE: begin
        inside_next  = pix_ok;
        sts.do_write = pix_ok;
      end
      MODE_READ: begin
        inside_next = pix_ok;
        sts.do_read = pix_ok;
      end
      MODE_SPAN: begin
        inside_next  = y_ok;
        sts.do_write = span_ok;
        cnt_next     = AW'($unsigned(span_len));
      end
      MODE_CLEAR: begin
        inside_next  = 1'b1;
        sts.do_write = 1'b1;
        addr_next    = '0;
        cnt_next     = AW'(DEPTH - 1);
      end
      default: begin
        inside_next = 1'b0;
      end
    endcase
    sts.last = (cnt == '0);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= mode_t'(in_mode);
      x_r    <= in_x;
      y_r    <= in_y;
      xe_r   <= in_xe;
      val_r  <= in_val;
    end
    if (cmd.setup) begin
      inside_r <= inside_next;
      rsel_r   <= sts.do_read;
      addr     <= addr_next;
      cnt      <= cnt_next;
    end else if (cmd.step) begin
      addr <= addr + AW'(1);
      cnt  <= cnt - AW'(1);
    end
    if (cmd.out_load) begin
      out_inside     <= inside_r;
      out_read_value <= rsel_r ? rdata : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[addr] <= val_r;
    end
    if (cmd.rd) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/cppe_ctrl.sv
// Controller state machine: command sequencing, write loop and result handshake.
`default_nettype none

module cppe_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  output logic           m_tvalid,
  input  logic           m_tready,
  input  cppe_pkg::sts_t sts,
  output cppe_pkg::cmd_t cmd
);
  import cppe_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_WRITE,
    ST_READ,
    ST_DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        cmd.load = s_tvalid;
        if (s_tvalid) begin
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        if (sts.do_write) begin
          state_next = ST_WRITE;
        end else if (sts.do_read) begin
          state_next = ST_READ;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_WRITE: begin
        cmd.wr   = 1'b1;
        cmd.step = !sts.last;
        if (sts.last) begin
          state_next = ST_DONE;
        end
      end
      ST_READ: begin
        cmd.rd     = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        cmd.out_load = !m_tvalid || m_tready;
        if (cmd.out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted twice without setup");

  a_out_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("result loaded over an untaken transfer");

  a_loop_continues: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr && !sts.last) |=> cmd.wr)
    else $error("write loop ended early");

  a_wr_rd_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(cmd.wr && cmd.rd))
    else $error("page store written and read together");

endmodule

`default_nettype wire

FILE: rtl/core/clipped_page_pixel_engine_unit.sv
// Top level of the clipped page pixel engine: controller, datapath and stream ports.
//
// Commands arrive on the slave stream: tuser carries the mode, tdata carries the
// coordinates and the colour. Each command gives exactly one result transfer on the
// master stream: tdata carries the read-back pixel, tuser the inside-page flag.
// A single pixel write or read passes through the setup state, one write or read state
// and the done state before its result is presented; a dropped or off-page command
// skips the write and read states. A span fill writes its clamped pixels, one page store
// write per cycle, and a page clear writes every pixel of the page, since the single page
// store port writes one pixel per cycle. The next command is accepted once the result is loaded.
// The result sits in an output register, so a new command is accepted while an
// earlier result waits; if the receiver stalls, the block holds the finished
// result of the following command until the register frees up.
// Reset clears the controller and the output valid; the page store is not cleared
// and must be written (for example with a page clear) before it is read.
`default_nettype none

module clipped_page_pixel_engine_unit #(
  parameter int unsigned PAGE_WIDTH  = 512,
  parameter int unsigned PAGE_HEIGHT = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // Fields from bit 0: pos_x[10:0], pos_y[21:11], span_end_x[32:22], pixel_value[40:33].
  input  logic [47:0] s_tdata,
  // Fields from bit 0: mode[2:0].
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // Fields from bit 0: read_value[7:0].
  output logic [7:0]  m_tdata,
  // Fields from bit 0: inside_page[0].
  output logic [0:0]  m_tuser
);
  import cppe_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cppe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cppe_datapath #(
    .PAGE_WIDTH  (PAGE_WIDTH),
    .PAGE_HEIGHT (PAGE_HEIGHT)
  ) u_datapath (
    .clk            (clk),
    .cmd            (cmd),
    .sts            (sts),
    .in_mode        (s_tuser),
    .in_x           ($signed(s_tdata[10:0])),
    .in_y           ($signed(s_tdata[21:11])),
    .in_xe          ($signed(s_tdata[32:22])),
    .in_val         (s_tdata[40:33]),
    .out_read_value (m_tdata),
    .out_inside     (m_tuser[0])
  );

endmodule

`default_nettype wire
